// ----- rtl/u16u8_pkg.sv -----
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
`default_nettype none

package u16u8_pkg;

    localparam int UNIT_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int CAP_W       = 11;
    localparam int CP_W        = 21;
    localparam int NBYTES_W    = 3;
    localparam int MAX_BYTES   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [CAP_W-1:0]  CAP_RESET   = 11'd64;
    localparam logic [0:0]        REG_OUT_CAPACITY = 1'd0;

    localparam logic [UNIT_W-1:0] HIGH_FIRST  = 16'hD800;
    localparam logic [UNIT_W-1:0] HIGH_LAST   = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LOW_FIRST   = 16'hDC00;
    localparam logic [UNIT_W-1:0] LOW_LAST    = 16'hDFFF;
    localparam logic [UNIT_W-1:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [UNIT_W-1:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [CP_W-1:0]   PLANE1_BASE = 21'h10000;

    localparam logic [BYTE_W-1:0] LEAD2 = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3 = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4 = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT  = 8'h80;

    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [NBYTES_W-1:0]              nbytes;
        logic                             close;
        logic                             status;
    } u16u8_entry_t;

endpackage

`default_nettype wire

// ----- rtl/u16u8_if.sv -----
// Valid/ready channel interfaces for code units in and UTF-8 results out.
`default_nettype none

interface u16u8_unit_if import u16u8_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] code_unit;
    logic              last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u16u8_result_if import u16u8_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              end_of_string;
    logic              status;

    modport source (output valid, output out_byte, output byte_valid,
                     output end_of_string, output status, input ready);
    modport sink (input valid, input out_byte, input byte_valid,
                  input end_of_string, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/u16u8_front.sv -----
// Front end: accepts code units, classifies them and encodes each character.
`default_nettype none

module u16u8_front import u16u8_pkg::*; #(
    parameter int MAX_CAPACITY = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    u16u8_unit_if.sink            units,
    input  wire logic [CAP_W-1:0] out_capacity,
    input  wire logic             q_ready,
    output logic                  q_push,
    output u16u8_entry_t          q_entry
);

    localparam logic [31:0] MAX_CAP32 = 32'(MAX_CAPACITY);

    logic [UNIT_W-1:0] pending_high_reg, pending_high_next;
    logic              have_pending_reg, have_pending_next;
    logic [CAP_W-1:0]  bytes_written_reg;
    logic              stopped_reg, stopped_next;
    logic              failed_reg, failed_next;

    logic [CAP_W-1:0]    cap;
    logic [CAP_W:0]      bw_x, cap_x;
    logic                fit1, fit2, fit3, fit4;
    logic                accept;
    logic                unit_high, unit_low;
    logic [UNIT_W-1:0]   unit;
    logic [CP_W-1:0]     cp;
    logic [NBYTES_W-1:0] nb;

    assign unit      = units.code_unit;
    assign accept    = units.valid && q_ready;
    assign units.ready = q_ready;
    assign unit_high = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
    assign unit_low  = (unit >= LOW_FIRST) && (unit <= LOW_LAST);

    assign cap   = ({21'd0, out_capacity} > MAX_CAP32) ? MAX_CAP32[CAP_W-1:0] : out_capacity;
    assign bw_x  = {1'b0, bytes_written_reg};
    assign cap_x = {1'b0, cap};
    assign fit1  = (bw_x + (CAP_W+1)'(1)) < cap_x;
    assign fit2  = (bw_x + (CAP_W+1)'(2)) < cap_x;
    assign fit3  = (bw_x + (CAP_W+1)'(3)) < cap_x;
    assign fit4  = (bw_x + (CAP_W+1)'(4)) < cap_x;

    assign cp = PLANE1_BASE + {1'b0, pending_high_reg[9:0], 10'd0} + {11'd0, unit[9:0]};

    always_comb
    begin
        q_entry           = '0;
        nb                = '0;
        failed_next       = failed_reg || (cap == '0);
        stopped_next      = stopped_reg;
        have_pending_next = have_pending_reg;
        pending_high_next = pending_high_reg;
        if (!stopped_reg && !failed_next)
        begin
            priority if (have_pending_reg)
            begin
                have_pending_next = 1'b0;
                pending_high_next = '0;
                if (unit_low && fit4)
                begin
                    nb               = 3'd4;
                    q_entry.bytes[0] = LEAD4 | {5'd0, cp[20:18]};
                    q_entry.bytes[1] = CONT | {2'd0, cp[17:12]};
                    q_entry.bytes[2] = CONT | {2'd0, cp[11:6]};
                    q_entry.bytes[3] = CONT | {2'd0, cp[5:0]};
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
            else if (!fit1)
            begin
                stopped_next = 1'b1;
            end
            else if (unit < ONE_BYTE_LIMIT)
            begin
                nb               = 3'd1;
                q_entry.bytes[0] = unit[7:0];
            end
            else if ((unit < TWO_BYTE_LIMIT) && fit2)
            begin
                nb               = 3'd2;
                q_entry.bytes[0] = LEAD2 | {3'd0, unit[10:6]};
                q_entry.bytes[1] = CONT | {2'd0, unit[5:0]};
            end
            else if (unit_high && !units.last_unit)
            begin
                pending_high_next = unit;
                have_pending_next = 1'b1;
            end
            else if (unit_low)
            begin
                failed_next = 1'b1;
            end
            else if (fit3)
            begin
                nb               = 3'd3;
                q_entry.bytes[0] = LEAD3 | {4'd0, unit[15:12]};
                q_entry.bytes[1] = CONT | {2'd0, unit[11:6]};
                q_entry.bytes[2] = CONT | {2'd0, unit[5:0]};
            end
            else
            begin
                stopped_next = 1'b1;
            end
        end
        q_entry.nbytes = nb;
        q_entry.close  = units.last_unit;
        q_entry.status = units.last_unit && failed_next;
        q_push         = accept && ((nb != '0) || units.last_unit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_high_reg  <= '0;
            have_pending_reg  <= 1'b0;
            bytes_written_reg <= '0;
            stopped_reg       <= 1'b0;
            failed_reg        <= 1'b0;
        end
        else if (accept)
        begin
            if (units.last_unit)
            begin
                pending_high_reg  <= '0;
                have_pending_reg  <= 1'b0;
                bytes_written_reg <= '0;
                stopped_reg       <= 1'b0;
                failed_reg        <= 1'b0;
            end
            else
            begin
                pending_high_reg  <= pending_high_next;
                have_pending_reg  <= have_pending_next;
                bytes_written_reg <= bytes_written_reg + CAP_W'(nb);
                stopped_reg       <= stopped_next;
                failed_reg        <= failed_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/u16u8_queue.sv -----
// Short queue of encoded characters between the front and back ends.
`default_nettype none

module u16u8_queue import u16u8_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  u16u8_entry_t push_entry,
    output logic       ready,
    input  wire logic  pop,
    output logic       head_valid,
    output u16u8_entry_t head_entry
);

    u16u8_entry_t      store [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign ready      = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = store[rd_ptr_reg];
    assign do_push    = push && ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/u16u8_back.sv -----
// Back end: splits each queued character into byte results behind an output register.
`default_nettype none

module u16u8_back import u16u8_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    head_valid,
    input  u16u8_entry_t head_entry,
    output logic         pop,
    u16u8_result_if.source results
);

    u16u8_entry_t      work_reg;
    logic              work_valid_reg;
    logic [1:0]        idx_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              byte_valid_reg;
    logic              eos_reg;
    logic              status_reg;

    logic              load_out;
    logic              last_of_entry;
    logic              empty_entry;

    assign empty_entry   = work_reg.nbytes == '0;
    assign last_of_entry = empty_entry || ({1'b0, idx_reg} == (work_reg.nbytes - 3'd1));
    assign load_out      = work_valid_reg && (!out_valid_reg || results.ready);
    assign pop           = head_valid && (!work_valid_reg || (load_out && last_of_entry));

    assign results.valid         = out_valid_reg;
    assign results.out_byte      = out_byte_reg;
    assign results.byte_valid    = byte_valid_reg;
    assign results.end_of_string = eos_reg;
    assign results.status        = status_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_byte_reg   <= empty_entry ? '0 : work_reg.bytes[idx_reg];
            byte_valid_reg <= !empty_entry;
            eos_reg        <= work_reg.close && last_of_entry;
            status_reg     <= work_reg.status && last_of_entry;
        end
        if (pop)
        begin
            work_reg <= head_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            work_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                work_valid_reg <= 1'b1;
                idx_reg        <= '0;
            end
            else if (load_out && last_of_entry)
            begin
                work_valid_reg <= 1'b0;
            end
            else if (load_out)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utf16_to_utf8_transcoder.sv -----
// Top level of the UTF-16 to UTF-8 transcoder with its configuration register.
`default_nettype none

// The block takes one UTF-16 code unit per transfer on the units channel and
// gives UTF-8 bytes, one per transfer, on the results channel; the last result
// of each string carries end_of_string and the status. A code unit is taken
// whenever the four-entry character queue has room, and a character costs up
// to four result transfers (four for a surrogate pair), so the single-byte
// output port sets the sustained rate. The first byte of a unit passes the
// queue entry, the work register and the output register before it is offered.
// The capacity register at byte address 0 counts the terminator slot; it is to
// be written only while no string is in flight, a rule on the user that the
// block itself does not enforce.
module utf16_to_utf8_transcoder import u16u8_pkg::*; #(
    parameter int MAX_CAPACITY = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    u16u8_unit_if.sink                 units,
    u16u8_result_if.source             results,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [CAP_W-1:0] out_capacity_reg;
    logic             reg_hit;
    logic             q_push, q_ready, q_pop, q_head_valid;
    u16u8_entry_t     q_entry, q_head_entry;

    assign pready  = 1'b1;
    assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_OUT_CAPACITY;

    always_comb
    begin
        prdata = '0;
        if (reg_hit)
        begin
            prdata = {{(APB_DATA_W-CAP_W){1'b0}}, out_capacity_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_capacity_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            out_capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    u16u8_front #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .units        (units),
        .out_capacity (out_capacity_reg),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_entry      (q_entry)
    );

    u16u8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    u16u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .results    (results)
    );

endmodule

`default_nettype wire

// ----- rtl/u16u8_checker.sv -----
// Port-level checks on the transcoder's result channel, bound to the top level.
`default_nettype none

module u16u8_checker import u16u8_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [BYTE_W-1:0] res_byte,
    input wire logic              res_byte_valid,
    input wire logic              res_eos,
    input wire logic              res_status
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_eos))
        else $error("result changed while stalled");

    a_close_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_byte_valid |-> res_eos && (res_byte == '0))
        else $error("status-only result does not close a string");

    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status |-> res_eos)
        else $error("status raised before the end of a string");

    a_lead_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_eos ##1 res_valid && res_byte_valid
        |-> res_byte[7:6] != 2'b10)
        else $error("string starts with a continuation byte");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (results.valid),
    .res_ready      (results.ready),
    .res_byte       (results.out_byte),
    .res_byte_valid (results.byte_valid),
    .res_eos        (results.end_of_string),
    .res_status     (results.status)
);

`default_nettype wire

// ----- test/utf16_to_utf8_transcoder_tb.sv -----
// Self-checking testbench of the UTF-16 to UTF-8 transcoder, predicting every result transfer.
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_tb;
    import u16u8_pkg::*;

    localparam int MAX_CAP = 1024;
    localparam int TOTAL_RANDOM_UNITS = 128;

    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              end_of_string;
        logic              status;
    } utf8_result_t;

    class utf8_scoreboard;
        utf8_result_t      awaited[$];
        int unsigned       mismatches;
        logic [CAP_W-1:0]  capacity;
        logic [UNIT_W-1:0] held_high;
        bit                holding;
        int unsigned       written;
        bit                stopped;
        bit                failed;

        function new();
            mismatches = 0;
            capacity   = CAP_RESET;
            clear_string();
        endfunction

        function void clear_string();
            held_high = '0;
            holding   = 1'b0;
            written   = 0;
            stopped   = 1'b0;
            failed    = 1'b0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", what);
        endfunction

        function void note_unit(logic [UNIT_W-1:0] cu, bit last);
            utf8_result_t      burst[$];
            utf8_result_t      one;
            logic [BYTE_W-1:0] seq[$];
            logic [CP_W-1:0]   cp;
            int unsigned       cap;
            int unsigned       used;
            bit                is_high;
            bit                is_low;
            cap     = (capacity > MAX_CAP) ? MAX_CAP : capacity;
            used    = written;
            is_high = (cu >= HIGH_FIRST) && (cu <= HIGH_LAST);
            is_low  = (cu >= LOW_FIRST) && (cu <= LOW_LAST);
            if (cap == 0)
                failed = 1'b1;
            if (!stopped && !failed)
            begin
                if (holding)
                begin
                    holding = 1'b0;
                    if (is_low && used + 4 < cap)
                    begin
                        cp = PLANE1_BASE + ((CP_W'(held_high) - CP_W'(HIGH_FIRST)) << 10)
                             + (CP_W'(cu) - CP_W'(LOW_FIRST));
                        seq.push_back(LEAD4 | {5'b0, cp[20:18]});
                        seq.push_back(CONT | {2'b0, cp[17:12]});
                        seq.push_back(CONT | {2'b0, cp[11:6]});
                        seq.push_back(CONT | {2'b0, cp[5:0]});
                    end
                    else
                    begin
                        failed = 1'b1;
                    end
                    held_high = '0;
                end
                else if (used + 1 >= cap)
                    stopped = 1'b1;
                else if (cu < ONE_BYTE_LIMIT)
                    seq.push_back(cu[7:0]);
                else if (cu < TWO_BYTE_LIMIT && used + 2 < cap)
                begin
                    seq.push_back(LEAD2 | {3'b0, cu[10:6]});
                    seq.push_back(CONT | {2'b0, cu[5:0]});
                end
                else if (is_high && !last)
                begin
                    held_high = cu;
                    holding   = 1'b1;
                end
                else if (is_low)
                    failed = 1'b1;
                else if (used + 3 < cap)
                begin
                    seq.push_back(LEAD3 | {4'b0, cu[15:12]});
                    seq.push_back(CONT | {2'b0, cu[11:6]});
                    seq.push_back(CONT | {2'b0, cu[5:0]});
                end
                else
                    stopped = 1'b1;
            end
            written += seq.size();
            foreach (seq[i])
            begin
                one.out_byte      = seq[i];
                one.byte_valid    = 1'b1;
                one.end_of_string = 1'b0;
                one.status        = 1'b0;
                burst.push_back(one);
            end
            if (last)
            begin
                if (burst.size() == 0)
                begin
                    one.out_byte   = '0;
                    one.byte_valid = 1'b0;
                    burst.push_back(one);
                end
                one = burst.pop_back();
                one.end_of_string = 1'b1;
                one.status        = failed;
                burst.push_back(one);
                clear_string();
            end
            foreach (burst[i])
                awaited.push_back(burst[i]);
        endfunction

        function void check_result(logic [BYTE_W-1:0] ob, logic bv, logic eos, logic st);
            utf8_result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result byte %02h valid %0d eos %0d status %0d",
                                 ob, bv, eos, st));
                return;
            end
            want = awaited.pop_front();
            if (ob !== want.out_byte || bv !== want.byte_valid ||
                eos !== want.end_of_string || st !== want.status)
                report($sformatf({"expected byte %02h valid %0d eos %0d status %0d, ",
                                  "got byte %02h valid %0d eos %0d status %0d"},
                                 want.out_byte, want.byte_valid, want.end_of_string,
                                 want.status, ob, bv, eos, st));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    u16u8_unit_if   units_ch ();
    u16u8_result_if results_ch ();

    utf8_scoreboard board;
    bit             calm;
    int unsigned    units_sent;

    utf16_to_utf8_transcoder #(
        .MAX_CAPACITY (MAX_CAP)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .units   (units_ch),
        .results (results_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        results_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (results_ch.valid && results_ch.ready)
                board.check_result(results_ch.out_byte, results_ch.byte_valid,
                                   results_ch.end_of_string, results_ch.status);
            results_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
        end
    end

    task automatic send_unit(logic [UNIT_W-1:0] cu, bit last);
        while (!calm && $urandom_range(0, 99) < 9)
        begin
            units_ch.valid <= 1'b0;
            @(posedge clk);
        end
        units_ch.valid     <= 1'b1;
        units_ch.code_unit <= cu;
        units_ch.last_unit <= last;
        do
            @(posedge clk);
        while (!units_ch.ready);
        board.note_unit(cu, last);
        units_sent++;
    endtask

    task automatic wait_for_results();
        units_ch.valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic read_capacity(logic [CAP_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(4 * REG_OUT_CAPACITY);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== APB_DATA_W'(want))
            board.report($sformatf("capacity read back %0d, expected %0d", got, want));
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_for_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * REG_OUT_CAPACITY);
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_capacity(value);
        @(posedge clk);
        read_capacity(value);
    endtask

    task automatic send_random_string(int unsigned max_len);
        logic [UNIT_W-1:0] text[$];
        int unsigned       len;
        int unsigned       kind;
        len = $urandom_range(1, max_len);
        while (text.size() < len)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 25)
                text.push_back(UNIT_W'($urandom_range(0, 'h7f)));
            else if (kind < 45)
                text.push_back(UNIT_W'($urandom_range('h80, 'h7ff)));
            else if (kind < 52)
                text.push_back(UNIT_W'($urandom_range('h800, 'hd7ff)));
            else if (kind < 60)
                text.push_back(UNIT_W'($urandom_range('he000, 'hffff)));
            else if (kind < 82)
            begin
                text.push_back(UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST)));
                text.push_back(UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST)));
            end
            else if (kind < 88)
                text.push_back(UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST)));
            else if (kind < 93)
                text.push_back(UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST)));
            else
                text.push_back(UNIT_W'($urandom()));
        end
        foreach (text[i])
            send_unit(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        int unsigned      phase;
        logic [CAP_W-1:0] phase_caps[12];
        board      = new();
        calm       = 1'b0;
        units_sent = 0;
        phase_caps = '{11'd2, 11'd5, 11'd64, 11'd8, 11'd1024, 11'd2047,
                       11'd3, 11'd1025, 11'd0, 11'd12, 11'd1, 11'd4};
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        units_ch.valid     <= 1'b0;
        units_ch.code_unit <= '0;
        units_ch.last_unit <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_capacity(CAP_RESET);

        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(HIGH_FIRST, 1'b0);
        wait_for_results();
        send_unit(LOW_FIRST, 1'b0);
        send_unit(HIGH_LAST, 1'b0);
        send_unit(LOW_LAST, 1'b1);
        send_unit(LOW_FIRST, 1'b0);
        send_unit(16'h0041, 1'b1);
        send_unit(HIGH_FIRST, 1'b0);
        send_unit(16'h0041, 1'b1);
        send_unit(HIGH_LAST, 1'b1);
        send_unit(HIGH_FIRST, 1'b0);
        send_unit(16'hD801, 1'b1);
        write_capacity(11'd1);
        send_unit(16'h0041, 1'b1);
        write_capacity(11'd0);
        send_unit(16'h0041, 1'b1);
        write_capacity(11'd3);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0100, 1'b0);
        send_unit(16'h0042, 1'b1);
        write_capacity(11'd4);
        send_unit(HIGH_FIRST, 1'b0);
        send_unit(LOW_FIRST, 1'b1);

        phase = 0;
        units_sent = 0;
        while (units_sent < TOTAL_RANDOM_UNITS)
        begin
            if (phase < 12)
                write_capacity(phase_caps[phase]);
            else
                write_capacity(CAP_W'($urandom_range(0, 80)));
            calm = (phase == 3) || (phase == 4);
            repeat (3) send_random_string(12);
            phase++;
        end
        calm = 1'b0;

        wait_for_results();
        repeat (20) @(posedge clk);
        if (board.awaited.size() != 0)
            board.report($sformatf("%0d results never arrived", board.awaited.size()));
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
